// ===== rtl/core/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// Camera trigger sequencer package
// Mode, phase and register index codes shared by the sequencer RTL.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned IndexW = 3;
  localparam int unsigned PhaseW = 4;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_LE  = 2'd1,
    MODE_TL  = 2'd2,
    MODE_TD  = 2'd3
  } mode_e;

  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_MODE = 1'b1
  } cmd_e;

  typedef enum logic [IndexW-1:0] {
    REG_FOCUS       = 3'd0,
    REG_SHUT_DELAY  = 3'd1,
    REG_LONG_EXP    = 3'd2,
    REG_SHUTTER     = 3'd3,
    REG_LAPSE_PER   = 3'd4,
    REG_LAPSE_DUR   = 3'd5,
    REG_DELAY_TOTAL = 3'd6
  } reg_idx_e;

  // Sequencer state, one-hot
  typedef enum logic [12:0] {
    PH_IDLE       = 13'b0_0000_0000_0001,
    PH_LE_FOCUS   = 13'b0_0000_0000_0010,
    PH_LE_DELAY   = 13'b0_0000_0000_0100,
    PH_LE_SHUTTER = 13'b0_0000_0000_1000,
    PH_TL_FOCUS   = 13'b0_0000_0001_0000,
    PH_TL_DELAY   = 13'b0_0000_0010_0000,
    PH_TL_SHUTTER = 13'b0_0000_0100_0000,
    PH_TL_WAIT    = 13'b0_0000_1000_0000,
    PH_TD_WAIT    = 13'b0_0001_0000_0000,
    PH_TD_FOCUS   = 13'b0_0010_0000_0000,
    PH_TD_DELAY   = 13'b0_0100_0000_0000,
    PH_TD_SHUTTER = 13'b0_1000_0000_0000,
    PH_CANCEL     = 13'b1_0000_0000_0000
  } phase_e;

  // Numeric phase code as seen on the result port
  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] code;
    case (ph)
      PH_IDLE:       code = 4'd0;
      PH_LE_FOCUS:   code = 4'd1;
      PH_LE_DELAY:   code = 4'd2;
      PH_LE_SHUTTER: code = 4'd3;
      PH_TL_FOCUS:   code = 4'd4;
      PH_TL_DELAY:   code = 4'd5;
      PH_TL_SHUTTER: code = 4'd6;
      PH_TL_WAIT:    code = 4'd7;
      PH_TD_WAIT:    code = 4'd8;
      PH_TD_FOCUS:   code = 4'd9;
      PH_TD_DELAY:   code = 4'd10;
      PH_TD_SHUTTER: code = 4'd11;
      default:       code = 4'd12;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/core/camera_trigger_sequencer.sv =====
// A transaction accepted into the input register steps the sequencer state
// registers, whose contents form the result.
// Throughput: one transaction per cycle while the result channel is not
// stalled; the tick increment and a threshold sum of up to four operands with
// its compare sit between the input and result registers.
// Reset (rst_ni low, asynchronous): idle phase, idle mode, both lines off,
// all counters and configuration registers zero, no result pending.
// ----------------------------------------------------------------------------
// Camera trigger sequencer
// Tick-driven focus/shutter sequencer for long exposure, time lapse and
// time delay modes, with one result per input transaction.
// ----------------------------------------------------------------------------
module camera_trigger_sequencer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cts_pkg::IndexW-1:0]  cfg_index_i,
  input  logic [cts_pkg::DataW-1:0]   cfg_data_i,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [1:0]                  requested_mode_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        focus_line_o,
  output logic                        shutter_line_o,
  output logic [1:0]                  active_mode_o,
  output logic [cts_pkg::PhaseW-1:0]  phase_o,
  output logic                        done_res_o
);
  import cts_pkg::*;

  // configuration registers
  logic [DataW-1:0] focus_q, sdelay_q, longexp_q, shutter_q;
  logic [DataW-1:0] period_q, duration_q, dtotal_q;

  // thresholds that depend only on configuration
  logic [DataW-1:0] fd, le_end, tl_shut, td_start, td_focus, td_end;
  logic [DataW:0]   td_need;
  logic [DataW+1:0] td_diff;

  // input register
  logic       in_valid_q, in_valid_d;
  cmd_e       cmd_q;
  mode_e      req_mode_q;

  // sequencer state
  phase_e           phase_q, phase_d;
  mode_e            mode_q, mode_d;
  logic [DataW-1:0] tick_q, tick_d, psum_q, psum_d;
  logic             focus_line_q, focus_line_d, shut_line_q, shut_line_d;
  logic             done_q, done_d;
  logic             out_valid_q, out_valid_d;

  logic             in_accept, step_en;
  logic [DataW-1:0] t;
  logic [DataW-1:0] thr_tl_focus, thr_tl_delay, thr_tl_shut, thr_tl_wait;
  logic             in_le, in_tl, in_td, mismatch;

  assign cfg_ready_o = 1'b1;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_q    <= '0;
      sdelay_q   <= '0;
      longexp_q  <= '0;
      shutter_q  <= '0;
      period_q   <= '0;
      duration_q <= '0;
      dtotal_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FOCUS:       focus_q    <= cfg_data_i;
        REG_SHUT_DELAY:  sdelay_q   <= cfg_data_i;
        REG_LONG_EXP:    longexp_q  <= cfg_data_i;
        REG_SHUTTER:     shutter_q  <= cfg_data_i;
        REG_LAPSE_PER:   period_q   <= cfg_data_i;
        REG_LAPSE_DUR:   duration_q <= cfg_data_i;
        REG_DELAY_TOTAL: dtotal_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    fd       = focus_q + sdelay_q;
    le_end   = longexp_q + fd;
    tl_shut  = shutter_q + fd;
    td_focus = dtotal_q - sdelay_q;
    td_end   = dtotal_q + shutter_q;
    td_need  = {1'b0, sdelay_q} + {1'b0, focus_q};
    td_diff  = {2'b00, dtotal_q} - {1'b0, td_need};
    // time delay start clamps at zero instead of wrapping
    td_start = td_diff[DataW+1] ? '0 : td_diff[DataW-1:0];
  end

  // ---- handshake ----
  assign in_stall_o  = in_valid_q & out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign step_en     = in_valid_q & ~(out_valid_q & out_stall_i);
  assign in_valid_d  = in_accept | (in_valid_q & ~step_en);
  assign out_valid_d = step_en | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q      <= cmd_e'(cmd_i);
      req_mode_q <= mode_e'(requested_mode_i);
    end
  end

  // ---- sequencer ----
  assign t = (phase_q != PH_IDLE) ? tick_q + 32'd1 : tick_q;

  assign thr_tl_focus = focus_q + psum_q;
  assign thr_tl_delay = fd + psum_q;
  assign thr_tl_shut  = tl_shut + psum_q;
  assign thr_tl_wait  = period_q + psum_q;

  assign in_le = (phase_q == PH_LE_FOCUS) || (phase_q == PH_LE_DELAY) ||
                 (phase_q == PH_LE_SHUTTER);
  assign in_tl = (phase_q == PH_TL_FOCUS) || (phase_q == PH_TL_DELAY) ||
                 (phase_q == PH_TL_SHUTTER) || (phase_q == PH_TL_WAIT);
  assign in_td = (phase_q == PH_TD_WAIT) || (phase_q == PH_TD_FOCUS) ||
                 (phase_q == PH_TD_DELAY) || (phase_q == PH_TD_SHUTTER);
  assign mismatch = (in_le && mode_q != MODE_LE) || (in_tl && mode_q != MODE_TL) ||
                    (in_td && mode_q != MODE_TD);

  always_comb begin
    phase_d      = phase_q;
    mode_d       = mode_q;
    tick_d       = tick_q;
    psum_d       = psum_q;
    focus_line_d = focus_line_q;
    shut_line_d  = shut_line_q;
    done_d       = 1'b0;
    if (cmd_q == CMD_MODE) begin
      mode_d = req_mode_q;
    end else begin
      tick_d = t;
      if (mismatch) begin
        phase_d = PH_CANCEL;
      end else begin
        case (phase_q)
          PH_IDLE: begin
            tick_d = '0;
            psum_d = '0;
            case (mode_q)
              MODE_LE: begin
                focus_line_d = 1'b1;
                phase_d      = PH_LE_FOCUS;
              end
              MODE_TL: begin
                focus_line_d = 1'b1;
                phase_d      = PH_TL_FOCUS;
              end
              MODE_TD: phase_d = PH_TD_WAIT;
              default: ;
            endcase
          end
          PH_LE_FOCUS: if (t >= focus_q) begin
            psum_d       = psum_q + focus_q;
            focus_line_d = 1'b0;
            phase_d      = PH_LE_DELAY;
          end
          PH_LE_DELAY: if (t >= fd) begin
            psum_d      = psum_q + sdelay_q;
            shut_line_d = 1'b1;
            phase_d     = PH_LE_SHUTTER;
          end
          PH_LE_SHUTTER: if (t >= le_end) begin
            mode_d      = MODE_OFF;
            shut_line_d = 1'b0;
            phase_d     = PH_IDLE;
            done_d      = 1'b1;
          end
          PH_TL_FOCUS: if (t >= thr_tl_focus) begin
            focus_line_d = 1'b0;
            phase_d      = PH_TL_DELAY;
          end
          PH_TL_DELAY: if (t >= thr_tl_delay) begin
            shut_line_d = 1'b1;
            phase_d     = PH_TL_SHUTTER;
          end
          PH_TL_SHUTTER: if (t >= thr_tl_shut) begin
            shut_line_d = 1'b0;
            phase_d     = PH_TL_WAIT;
          end
          PH_TL_WAIT: if (t >= thr_tl_wait) begin
            psum_d = thr_tl_wait;
            if (t >= duration_q) begin
              mode_d  = MODE_OFF;
              phase_d = PH_IDLE;
              done_d  = 1'b1;
            end else begin
              focus_line_d = 1'b1;
              phase_d      = PH_TL_FOCUS;
            end
          end
          PH_TD_WAIT: if (t >= td_start) begin
            focus_line_d = 1'b1;
            phase_d      = PH_TD_FOCUS;
          end
          PH_TD_FOCUS: if (t >= td_focus) begin
            focus_line_d = 1'b0;
            phase_d      = PH_TD_DELAY;
          end
          PH_TD_DELAY: if (t >= dtotal_q) begin
            shut_line_d = 1'b1;
            phase_d     = PH_TD_SHUTTER;
          end
          PH_TD_SHUTTER: if (t >= td_end) begin
            mode_d      = MODE_OFF;
            shut_line_d = 1'b0;
            phase_d     = PH_IDLE;
            done_d      = 1'b1;
          end
          default: begin
            // cancel: drop both lines, keep the mode
            phase_d      = PH_IDLE;
            shut_line_d  = 1'b0;
            focus_line_d = 1'b0;
            tick_d       = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      mode_q       <= MODE_OFF;
      tick_q       <= '0;
      psum_q       <= '0;
      focus_line_q <= 1'b0;
      shut_line_q  <= 1'b0;
      done_q       <= 1'b0;
    end else if (step_en) begin
      phase_q      <= phase_d;
      mode_q       <= mode_d;
      tick_q       <= tick_d;
      psum_q       <= psum_d;
      focus_line_q <= focus_line_d;
      shut_line_q  <= shut_line_d;
      done_q       <= done_d;
    end
  end

  // state registers only move when the result slot frees, so they are the result
  assign out_valid_o    = out_valid_q;
  assign focus_line_o   = focus_line_q;
  assign shutter_line_o = shut_line_q;
  assign active_mode_o  = mode_q;
  assign phase_o        = phase_code(phase_q);
  assign done_res_o     = done_q;

  // ---- assertions ----
  a_lines_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(focus_line_q && shut_line_q))
    else $error("focus and shutter lines both active");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (phase_q == PH_IDLE && mode_q == MODE_OFF))
    else $error("done reported outside idle");

  a_focus_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LE_FOCUS || phase_q == PH_TL_FOCUS || phase_q == PH_TD_FOCUS)
    |-> focus_line_q)
    else $error("focus phase without focus line");

  a_pending_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("pending transaction did not produce a result");

endmodule
